[src/rbpf_pkg.sv]
// shared types, register indexes and pixel packing for the rect blit formatter
// no dependencies
package rbpf_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int OFF_W           = 27;
  localparam int CFG_IDX_W       = 3;
  localparam int MODE_W          = 3;
  localparam int NB_W            = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_W     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_H     = 3'd7;

  localparam logic [MODE_W-1:0] MODE_RGB332 = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RGB555 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RGB565 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RGB888 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_XRGB   = 3'd4;

  localparam logic [NB_W-1:0] NB_ONE   = 3'd1;
  localparam logic [NB_W-1:0] NB_TWO   = 3'd2;
  localparam logic [NB_W-1:0] NB_THREE = 3'd3;
  localparam logic [NB_W-1:0] NB_FOUR  = 3'd4;

  typedef struct packed {
    logic [31:0]     data;
    logic [NB_W-1:0] nbytes;
    logic            done;
  } pix_t;

  function automatic logic [31:0] pack_pixel(input logic [31:0] c, input logic [MODE_W-1:0] mode);
    logic [31:0] d;
    d = '0;
    case (mode)
      MODE_RGB332: d = {24'h0, c[23:21], c[15:13], c[7:6]};
      MODE_RGB555: d = {17'h0, c[23:19], c[15:11], c[7:3]};
      MODE_RGB565: d = {16'h0, c[23:19], c[15:10], c[7:3]};
      MODE_RGB888: d = {8'h0, c[23:0]};
      default:     d = c;
    endcase
    return d;
  endfunction

  function automatic logic [NB_W-1:0] mode_bytes(input logic [MODE_W-1:0] mode);
    logic [NB_W-1:0] n;
    n = NB_FOUR;
    case (mode)
      MODE_RGB332: n = NB_ONE;
      MODE_RGB555: n = NB_TWO;
      MODE_RGB565: n = NB_TWO;
      MODE_RGB888: n = NB_THREE;
      default:     n = NB_FOUR;
    endcase
    return n;
  endfunction

endpackage

[src/rbpf_pix_if.sv]
// source pixel channel: valid, ready and one 0x00RRGGBB colour
// no dependencies
interface rbpf_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_color;

  modport source(output valid, output src_color, input ready);
  modport sink(input valid, input src_color, output ready);
endinterface

[src/rbpf_wr_if.sv]
// framebuffer write request channel
// no dependencies
interface rbpf_wr_if;
  logic        valid;
  logic        ready;
  logic [26:0] byte_offset;
  logic [31:0] write_data;
  logic [2:0]  byte_count;
  logic        region_done;

  modport source(output valid, output byte_offset, output write_data, output byte_count,
                 output region_done, input ready);
  modport sink(input valid, input byte_offset, input write_data, input byte_count,
               input region_done, output ready);
endinterface

[src/rbpf_queue.sv]
// short flop queue between the front and back parts
// no dependencies
module rbpf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push || pop)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
                                  count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
`endif
endmodule

[src/rbpf_front.sv]
// front part: registers, region counters, screen position and pixel packing
// depends on rbpf_pkg and rbpf_pix_if
module rbpf_front #(
  parameter int COORD_BITS = rbpf_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rbpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_BITS:0]            cfg_data,
  rbpf_pix_if.sink                       in_ch,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [COORD_BITS+1:0]          q_x,
  output logic [COORD_BITS+1:0]          q_y,
  output rbpf_pkg::pix_t                 q_pix,
  output logic [COORD_BITS:0]            screen_width
);
  import rbpf_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int SZ_W = COORD_BITS + 1;
  localparam int XY_W = COORD_BITS + 2;

  logic [MODE_W-1:0] mode_r;
  logic [SZ_W-1:0]   swidth_r, region_w_r, region_h_r;
  logic [CB-1:0]     dest_x_r, dest_y_r, region_x_r, region_y_r;
  logic [CB-1:0]     col_r, col_nxt, row_r, row_nxt;
  logic [SZ_W-1:0]   eff_w, eff_h, col_inc, row_inc;
  logic              end_col, end_row, accept;

  localparam logic [SZ_W-1:0] SIZE_MAX = SZ_W'(1) << CB;

  assign in_ch.ready  = !q_full;
  assign accept       = in_ch.valid && !q_full;
  assign q_push       = accept;
  assign screen_width = swidth_r;

  always_comb begin
    eff_w = region_w_r;
    if (region_w_r == '0) begin
      eff_w = SZ_W'(1);
    end else if (region_w_r > SIZE_MAX) begin
      eff_w = SIZE_MAX;
    end
    eff_h = region_h_r;
    if (region_h_r == '0) begin
      eff_h = SZ_W'(1);
    end else if (region_h_r > SIZE_MAX) begin
      eff_h = SIZE_MAX;
    end
  end

  assign col_inc = {1'b0, col_r} + SZ_W'(1);
  assign row_inc = {1'b0, row_r} + SZ_W'(1);
  assign end_col = (col_inc >= eff_w);
  assign end_row = (row_inc >= eff_h);

  assign q_x = XY_W'(dest_x_r) + XY_W'(region_x_r) + XY_W'(col_r);
  assign q_y = XY_W'(dest_y_r) + XY_W'(region_y_r) + XY_W'(row_r);

  always_comb begin
    q_pix.data   = pack_pixel(in_ch.src_color, mode_r);
    q_pix.nbytes = mode_bytes(mode_r);
    q_pix.done   = end_col && end_row;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (end_col) begin
        col_nxt = '0;
        row_nxt = end_row ? '0 : row_inc[CB-1:0];
      end else begin
        col_nxt = col_inc[CB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_XRGB;
      swidth_r   <= SZ_W'(1024);
      dest_x_r   <= '0;
      dest_y_r   <= '0;
      region_x_r <= '0;
      region_y_r <= '0;
      region_w_r <= SZ_W'(1);
      region_h_r <= SZ_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIXEL_MODE:   mode_r     <= cfg_data[MODE_W-1:0];
        REG_SCREEN_WIDTH: swidth_r   <= cfg_data;
        REG_DEST_X:       dest_x_r   <= cfg_data[CB-1:0];
        REG_DEST_Y:       dest_y_r   <= cfg_data[CB-1:0];
        REG_REGION_X:     region_x_r <= cfg_data[CB-1:0];
        REG_REGION_Y:     region_y_r <= cfg_data[CB-1:0];
        REG_REGION_W:     region_w_r <= cfg_data;
        REG_REGION_H:     region_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_wraps: assert property (@(posedge clk) disable iff (!rst_n)
                                 accept && q_pix.done |=> col_r == '0 && row_r == '0)
    else $error("counters not cleared after last pixel");
  a_col_hold: assert property (@(posedge clk) disable iff (!rst_n)
                               !accept |=> $stable(col_r) && $stable(row_r))
    else $error("counters moved without a request");
`endif
endmodule

[src/rbpf_back.sv]
// back part: line multiply, byte scaling and the output register
// depends on rbpf_pkg and rbpf_wr_if
module rbpf_back #(
  parameter int COORD_BITS = rbpf_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic [COORD_BITS+1:0] q_x,
  input  logic [COORD_BITS+1:0] q_y,
  input  rbpf_pkg::pix_t        q_pix,
  input  logic [COORD_BITS:0]   screen_width,
  rbpf_wr_if.source             out_ch
);
  import rbpf_pkg::*;

  localparam int SZ_W   = COORD_BITS + 1;
  localparam int XY_W   = COORD_BITS + 2;
  localparam int PROD_W = SZ_W + XY_W;

  logic [PROD_W-1:0] prod;
  logic [OFF_W-1:0]  mid_lin_r, scaled;
  pix_t              mid_pix_r;
  logic              mid_valid_r, out_valid_r, mid_ready, out_ready;
  logic [OFF_W-1:0]  out_off_r;
  pix_t              out_pix_r;

  assign out_ready = !out_valid_r || out_ch.ready;
  assign mid_ready = !mid_valid_r || out_ready;
  assign q_pop     = !q_empty && mid_ready;
  assign prod      = PROD_W'(screen_width) * PROD_W'(q_y);

  always_comb begin
    case (mid_pix_r.nbytes)
      NB_ONE:   scaled = mid_lin_r;
      NB_TWO:   scaled = mid_lin_r << 1;
      NB_THREE: scaled = mid_lin_r + (mid_lin_r << 1);
      default:  scaled = mid_lin_r << 2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (mid_ready) begin
        mid_valid_r <= q_pop;
      end
      if (out_ready) begin
        out_valid_r <= mid_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mid_lin_r <= OFF_W'(prod) + OFF_W'(q_x);
      mid_pix_r <= q_pix;
    end
    if (out_ready && mid_valid_r) begin
      out_off_r <= scaled;
      out_pix_r <= mid_pix_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.byte_offset = out_off_r;
  assign out_ch.write_data  = out_pix_r.data;
  assign out_ch.byte_count  = out_pix_r.nbytes;
  assign out_ch.region_done = out_pix_r.done;

`ifndef ASSERT_OFF
  a_mid_held: assert property (@(posedge clk) disable iff (!rst_n)
                               mid_valid_r && !out_ready |=> mid_valid_r)
    else $error("pipeline entry lost under stall");
  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> mid_valid_r)
    else $error("popped entry not captured");
`endif
endmodule

[src/rect_blit_pixel_formatter.sv]
// top level of the rect blit pixel formatter: front, queue and back
// depends on rbpf_pkg, rbpf_pix_if, rbpf_wr_if, rbpf_queue, rbpf_front, rbpf_back
//
// Usage: write the eight registers through cfg_we/cfg_index/cfg_data while the
// block is idle, then stream the region's source pixels in raster order on in_ch.
// Each accepted pixel gives exactly one write request on out_ch carrying the
// framebuffer byte offset, the packed data, the byte count and a flag on the
// region's last pixel.
// Throughput is one pixel per clock while out_ch is not stalled, set by the single
// line multiply in the back part; an accepted pixel passes through the queue, the
// middle register and the output register before it shows on out_ch.
// A four-entry queue parts the front from the back, so in_ch keeps accepting
// while out_ch is stalled until the queue and the two back registers are full;
// in_ch.ready then drops until the receiver takes a request.
// Reset (rst_n low, synchronous) clears the counters and queue, empties the
// output, and loads the register defaults: 32-bit mode, screen width 1024,
// all origins zero and a one by one region.
module rect_blit_pixel_formatter #(
  parameter int COORD_BITS  = rbpf_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = rbpf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rbpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_BITS:0]            cfg_data,
  rbpf_pix_if.sink                       in_ch,
  rbpf_wr_if.source                      out_ch
);
  import rbpf_pkg::*;

  localparam int XY_W  = COORD_BITS + 2;
  localparam int PIX_W = $bits(pix_t);
  localparam int ENT_W = 2 * XY_W + PIX_W;

  logic              q_push, q_pop, q_full, q_empty;
  logic [XY_W-1:0]   f_x, f_y, b_x, b_y;
  pix_t              f_pix, b_pix;
  logic [ENT_W-1:0]  q_wdata, q_rdata;
  logic [COORD_BITS:0] screen_width;

  assign q_wdata = {f_x, f_y, f_pix};
  assign b_x     = q_rdata[ENT_W-1 -: XY_W];
  assign b_y     = q_rdata[PIX_W +: XY_W];
  assign b_pix   = q_rdata[PIX_W-1:0];

  rbpf_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_ch        (in_ch),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_x          (f_x),
    .q_y          (f_y),
    .q_pix        (f_pix),
    .screen_width (screen_width)
  );

  rbpf_queue #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  rbpf_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_x          (b_x),
    .q_y          (b_y),
    .q_pix        (b_pix),
    .screen_width (screen_width),
    .out_ch       (out_ch)
  );
endmodule
